@@ rtl/pet_pkg.sv @@
// Shared types and constants for the Prewitt edge threshold block.
// No dependencies; every file but pet_ram imports this package.
package pet_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int ROWS_MAX  = 256;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int DIM_W     = 9;
	localparam int THR_W     = 21;
	localparam int PIX_W     = 8;
	localparam int SUM_W     = 10;
	localparam int GRAD_W    = 11;
	localparam int SQ_W      = 20;

	localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);
	localparam logic [DIM_W-1:0] MAX_COLS     = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_ROWS     = DIM_W'(ROWS_MAX);
	localparam logic [DIM_W-1:0] RST_WIDTH    = DIM_W'(256);
	localparam logic [DIM_W-1:0] RST_HEIGHT   = DIM_W'(256);
	localparam logic [THR_W-1:0] RST_THRESH   = THR_W'(8281);

	// x / 3 for x < 2048 is (x * 683) >> 11
	localparam logic [SUM_W-1:0] DIV3_MUL   = SUM_W'(683);
	localparam int               DIV3_SHIFT = 11;

	typedef enum logic [1:0] {
		REG_LINE_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_THRESHOLD_SQ = 2'd2
	} pet_reg_t;

	// position information of one accepted item
	typedef struct packed {
		logic [ADDR_W-1:0] col;
		logic              emit;
		logic              top_ok;
		logic              bot_ok;
		logic              left_ok;
		logic              right_ok;
		logic              eof;
	} pet_pos_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic                     eof;
	} pet_grad_t;

endpackage

@@ rtl/pet_ram.sv @@
// Generic single-write, single-read RAM with registered read-first output.
// No dependencies.
module pet_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/pet_scan.sv @@
// Raster position counters, border flags and gray conversion for each item.
// Depends on pet_pkg.
module pet_scan import pet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [DIM_W-1:0]  line_width,
	input  logic [DIM_W-1:0]  frame_height,
	input  logic [PIX_W-1:0]  red,
	input  logic [PIX_W-1:0]  green,
	input  logic [PIX_W-1:0]  blue,
	input  logic              flush,
	output pet_pos_t          pos,
	output logic [PIX_W-1:0]  gray
);

	logic [DIM_W-1:0]       row_q, col_q;
	logic [DIM_W-1:0]       w, h, h1;
	logic [DIM_W-1:0]       r, c, cr, cc;
	logic [DIM_W-1:0]       r_nxt, c_nxt;
	logic                   restart, pad;
	logic [SUM_W-1:0]       sum;
	logic [2*SUM_W-1:0]     prod;

	always_comb begin
		w = (line_width < MIN_DIM) ? MIN_DIM :
			((line_width > MAX_COLS) ? MAX_COLS : line_width);
		h = (frame_height < MIN_DIM) ? MIN_DIM :
			((frame_height > MAX_ROWS) ? MAX_ROWS : frame_height);
		h1 = h + DIM_W'(1);

		// counters past the frame: start a new frame
		restart = (col_q >= w) || (row_q > h1) || ((row_q == h1) && (col_q != '0));
		r = restart ? '0 : row_q;
		c = restart ? '0 : col_q;

		pad  = flush || (r >= h);
		sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
		prod = (2*SUM_W)'(sum) * (2*SUM_W)'(DIV3_MUL);
		gray = pad ? '0 : prod[DIV3_SHIFT +: PIX_W];

		if (c != '0) begin
			pos.emit = (r >= DIM_W'(1)) && (r <= h);
			cr = r - DIM_W'(1);
			cc = c - DIM_W'(1);
		end else begin
			pos.emit = (r >= DIM_W'(2)) && (r <= h1);
			cr = r - DIM_W'(2);
			cc = w - DIM_W'(1);
		end
		pos.col      = c[ADDR_W-1:0];
		pos.top_ok   = (cr != '0);
		pos.bot_ok   = ((cr + DIM_W'(1)) < h);
		pos.left_ok  = (cc != '0);
		pos.right_ok = ((cc + DIM_W'(1)) < w);
		pos.eof      = (cr == (h - DIM_W'(1))) && (cc == (w - DIM_W'(1)));

		if (r == h1) begin
			r_nxt = '0;
			c_nxt = '0;
		end else if ((c + DIM_W'(1)) >= w) begin
			r_nxt = r + DIM_W'(1);
			c_nxt = '0;
		end else begin
			r_nxt = r;
			c_nxt = c + DIM_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= r_nxt;
			col_q <= c_nxt;
		end
	end

endmodule

@@ rtl/pet_window.sv @@
// Line store, 3x3 gray window and Prewitt gradients (stages s1 and s2).
// Depends on pet_pkg and pet_ram.
module pet_window import pet_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             advance,
	input  pet_pos_t         pos,
	input  logic [PIX_W-1:0] gray,
	output logic             emit_s1,
	output pet_grad_t        grad_s2
);

	pet_pos_t              pos_s1;
	logic [PIX_W-1:0]      gray_s1;
	logic                  fwd_s1;
	logic [2*PIX_W-1:0]    fwd_data_q;
	logic [2*PIX_W-1:0]    rdata, entry, wdata;
	logic [PIX_W-1:0]      top, mid;
	logic [PIX_W-1:0]      win_q [9];
	logic [PIX_W-1:0]      nwin [9];
	logic [PIX_W-1:0]      v [9];
	logic [SUM_W-1:0]      s_left, s_right, s_top, s_bot;

	// one entry per column: {row before previous, previous row}
	pet_ram #(
		.WIDTH (2*PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (advance),
		.waddr (pos_s1.col),
		.wdata (wdata),
		.re    (load),
		.raddr (pos.col),
		.rdata (rdata)
	);

	always_comb begin
		// same column written on the edge it was read: take the new data
		entry = fwd_s1 ? fwd_data_q : rdata;
		top   = entry[2*PIX_W-1:PIX_W];
		mid   = entry[PIX_W-1:0];
		wdata = {mid, gray_s1};

		for (int i = 0; i < 3; i++) begin
			nwin[i*3]     = win_q[i*3+1];
			nwin[i*3 + 1] = win_q[i*3+2];
		end
		nwin[2] = top;
		nwin[5] = mid;
		nwin[8] = gray_s1;

		for (int k = 0; k < 9; k++) begin
			v[k] = nwin[k];
		end
		if (!pos_s1.top_ok) begin
			v[0] = '0; v[1] = '0; v[2] = '0;
		end
		if (!pos_s1.bot_ok) begin
			v[6] = '0; v[7] = '0; v[8] = '0;
		end
		if (!pos_s1.left_ok) begin
			v[0] = '0; v[3] = '0; v[6] = '0;
		end
		if (!pos_s1.right_ok) begin
			v[2] = '0; v[5] = '0; v[8] = '0;
		end

		s_left  = SUM_W'(v[0]) + SUM_W'(v[3]) + SUM_W'(v[6]);
		s_right = SUM_W'(v[2]) + SUM_W'(v[5]) + SUM_W'(v[8]);
		s_top   = SUM_W'(v[0]) + SUM_W'(v[1]) + SUM_W'(v[2]);
		s_bot   = SUM_W'(v[6]) + SUM_W'(v[7]) + SUM_W'(v[8]);
	end

	assign emit_s1 = pos_s1.emit;

	always_ff @(posedge clk) begin
		if (load) begin
			pos_s1  <= pos;
			gray_s1 <= gray;
		end
		if (advance) begin
			fwd_data_q  <= wdata;
			grad_s2.gx  <= $signed({1'b0, s_left}) - $signed({1'b0, s_right});
			grad_s2.gy  <= $signed({1'b0, s_top}) - $signed({1'b0, s_bot});
			grad_s2.eof <= pos_s1.eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (load) begin
				fwd_s1 <= advance && (pos_s1.col == pos.col);
			end
			if (advance) begin
				win_q <= nwin;
			end
		end
	end

endmodule

@@ rtl/pet_mag.sv @@
// Squared gradient magnitude and threshold compare (stage s3 and output register).
// Depends on pet_pkg.
module pet_mag import pet_pkg::*; (
	input  logic             clk,
	input  logic             load_s3,
	input  pet_grad_t        grad_s2,
	input  logic             load_out,
	input  logic [THR_W-1:0] threshold_sq,
	output logic             is_edge,
	output logic             end_of_frame
);

	logic signed [2*GRAD_W-1:0] sqx, sqy;
	logic [SQ_W-1:0]            sqx_s3, sqy_s3;
	logic                       eof_s3;
	logic [THR_W-1:0]           mag;

	assign sqx = $signed(grad_s2.gx) * $signed(grad_s2.gx);
	assign sqy = $signed(grad_s2.gy) * $signed(grad_s2.gy);
	assign mag = THR_W'(sqx_s3) + THR_W'(sqy_s3);

	always_ff @(posedge clk) begin
		if (load_s3) begin
			sqx_s3 <= sqx[SQ_W-1:0];
			sqy_s3 <= sqy[SQ_W-1:0];
			eof_s3 <= grad_s2.eof;
		end
		if (load_out) begin
			is_edge      <= (mag >= threshold_sq);
			end_of_frame <= eof_s3;
		end
	end

endmodule

@@ rtl/prewitt_edge_threshold_top.sv @@
// Top level of the Prewitt edge threshold block: register file, handshakes.
// Depends on pet_pkg, pet_scan, pet_window, pet_mag (and pet_ram below it).
//
// Usage:
//   Input channel (in_valid/in_ready): one RGB pixel per transfer in raster
//   order; after each frame send line_width+1 items with flush set to drain
//   the last row. Output channel (out_valid/out_ready): one is_edge result
//   per centre pixel, end_of_frame set on the frame's last pixel. Results
//   trail the input stream by one row plus one pixel.
//   Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high;
//   cfg_index selects line_width, frame_height or threshold_sq. Write only
//   while no item is in flight.
//   Throughput: one item per cycle while out_ready drains the output. An
//   input transfer's result passes the line store read, gradient stage,
//   square stage and output register in that order.
//   Reset: counters, valid bits and window clear at once; no clearing pass.
//   Line store entries are always written before their data reach a result.
//   Stalls: each stage holds when the next is full and not advancing; items
//   that complete no centre pixel drop out after the line store stage, so the
//   input keeps moving while a result waits as long as a free stage remains.
module prewitt_edge_threshold_top import pet_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [THR_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] red,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] blue,
	input  logic             flush,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             is_edge,
	output logic             end_of_frame
);

	logic [DIM_W-1:0]  line_width_q, frame_height_q;
	logic [THR_W-1:0]  threshold_sq_q;
	logic              v1_q, v2_q, v3_q, out_valid_q;
	logic              out_free, ready2, ready1, adv1, adv2, adv3, accept;
	logic              emit_s1;
	pet_pos_t          pos;
	logic [PIX_W-1:0]  gray;
	pet_grad_t         grad_s2;

	// Configuration: always ready, decode index
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= RST_WIDTH;
			frame_height_q <= RST_HEIGHT;
			threshold_sq_q <= RST_THRESH;
		end else if (cfg_valid) begin
			case (pet_reg_t'(cfg_index))
				REG_LINE_WIDTH:   line_width_q   <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				REG_THRESHOLD_SQ: threshold_sq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow: a stage advances when the next is empty or advancing
	assign out_free = !out_valid_q || out_ready;
	assign adv3     = v3_q && out_free;
	assign ready2   = !v3_q || out_free;
	assign adv2     = v2_q && ready2;
	assign ready1   = !v2_q || ready2;
	assign adv1     = v1_q && ready1;
	assign in_ready = !v1_q || ready1;
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// stage 1 holds every item; only emitting ones go on to stage 2
			if (accept) begin
				v1_q <= 1'b1;
			end else if (adv1) begin
				v1_q <= 1'b0;
			end
			if (adv1) begin
				v2_q <= emit_s1;
			end else if (adv2) begin
				v2_q <= 1'b0;
			end
			if (adv2) begin
				v3_q <= 1'b1;
			end else if (adv3) begin
				v3_q <= 1'b0;
			end
			if (adv3) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	pet_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.line_width   (line_width_q),
		.frame_height (frame_height_q),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.flush        (flush),
		.pos          (pos),
		.gray         (gray)
	);

	pet_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.advance (adv1),
		.pos     (pos),
		.gray    (gray),
		.emit_s1 (emit_s1),
		.grad_s2 (grad_s2)
	);

	pet_mag u_mag (
		.clk          (clk),
		.load_s3      (adv2),
		.grad_s2      (grad_s2),
		.load_out     (adv3),
		.threshold_sq (threshold_sq_q),
		.is_edge      (is_edge),
		.end_of_frame (end_of_frame)
	);

`ifndef SYNTHESIS
	// an emitting item leaving stage 1 lands in stage 2
	a_emit_reaches_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && emit_s1 |=> v2_q)
		else $error("emitting item lost after line store stage");

	// a blocked stage 2 keeps its gradients
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q && !ready2 |=> v2_q && $stable(grad_s2))
		else $error("stage 2 changed while blocked");

	// stage 3 transfer fills the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv3 |=> out_valid_q)
		else $error("result dropped at output register");

	// input transfer only into a free or draining stage 1
	a_s1_free: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!v1_q || adv1))
		else $error("stage 1 overwritten");
`endif

endmodule
